// ===== design/afte_pkg.sv =====
`default_nettype none
package afte_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] frame_len;
  } in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       run_last;
    logic       frame_end;
  } out_t;

  typedef struct packed {
    logic [63:0] dest_addr64;
    logic [15:0] dest_addr16;
    logic [7:0]  radius;
    logic [7:0]  tx_options;
    logic [7:0]  api_id;
    logic [7:0]  frame_id;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_HDR,
    ST_DATA,
    ST_CHECK
  } state_e;

  typedef enum logic [2:0] {
    SRC_START,
    SRC_LEN_HI,
    SRC_LEN_LO,
    SRC_HDR,
    SRC_DATA,
    SRC_CHECK
  } src_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       take;
    logic       first;
    src_e       src;
    logic [3:0] hdr_idx;
    logic       emit;
    logic       esc_mark;
    logic       flip;
    logic       add_sum;
    logic       dec_cnt;
    logic       run_last;
    logic       frame_end;
  } cmd_t;

  // status from the datapath back to the controller
  typedef struct packed {
    logic out_free;
    logic needs_esc;
    logic cnt_zero;
    logic cnt_one;
  } sts_t;

  localparam logic [7:0] MaxPayload = 8'd243;
  localparam logic [8:0] LenExtra   = 9'd14;
  localparam logic [7:0] StartMark  = 8'h7E;
  localparam logic [7:0] EscMark    = 8'h7D;
  localparam logic [7:0] EscFlip    = 8'h20;
  localparam logic [7:0] Xon        = 8'h11;
  localparam logic [7:0] Xoff       = 8'h13;
  localparam logic [3:0] HdrLast    = 4'd13;

  localparam logic [2:0] RegDest64  = 3'd0;
  localparam logic [2:0] RegDest16  = 3'd1;
  localparam logic [2:0] RegRadius  = 3'd2;
  localparam logic [2:0] RegOptions = 3'd3;
  localparam logic [2:0] RegApiId   = 3'd4;
  localparam logic [2:0] RegFrameId = 3'd5;

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == StartMark) || (b == EscMark) || (b == Xon) || (b == Xoff);
  endfunction

endpackage
`default_nettype wire

// ===== design/afte_cfg.sv =====
`default_nettype none
module afte_cfg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [5:0]        paddr,
  input  wire logic [63:0]       pwdata,
  output logic      [63:0]       prdata,
  output logic                   pready,
  output afte_pkg::cfg_t         cfg_o
);

  afte_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        afte_pkg::RegDest64:  cfg_d.dest_addr64 = pwdata;
        afte_pkg::RegDest16:  cfg_d.dest_addr16 = pwdata[15:0];
        afte_pkg::RegRadius:  cfg_d.radius      = pwdata[7:0];
        afte_pkg::RegOptions: cfg_d.tx_options  = pwdata[7:0];
        afte_pkg::RegApiId:   cfg_d.api_id      = pwdata[7:0];
        afte_pkg::RegFrameId: cfg_d.frame_id    = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      afte_pkg::RegDest64:  prdata = cfg_q.dest_addr64;
      afte_pkg::RegDest16:  prdata = {48'd0, cfg_q.dest_addr16};
      afte_pkg::RegRadius:  prdata = {56'd0, cfg_q.radius};
      afte_pkg::RegOptions: prdata = {56'd0, cfg_q.tx_options};
      afte_pkg::RegApiId:   prdata = {56'd0, cfg_q.api_id};
      afte_pkg::RegFrameId: prdata = {56'd0, cfg_q.frame_id};
      default:              prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_addr64 <= 64'd0;
      cfg_q.dest_addr16 <= 16'hFFFE;
      cfg_q.radius      <= 8'd0;
      cfg_q.tx_options  <= 8'd0;
      cfg_q.api_id      <= 8'h10;
      cfg_q.frame_id    <= 8'h01;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/afte_dp.sv =====
`default_nettype none
module afte_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire afte_pkg::in_t  in_req_i,
  input  wire afte_pkg::cfg_t cfg_i,
  input  wire afte_pkg::cmd_t cmd_i,
  input  wire logic           out_ready_i,
  output afte_pkg::out_t      out_rsp_o,
  output logic                out_valid_o,
  output afte_pkg::sts_t      sts_o
);

  logic [7:0]     data_q;
  logic [7:0]     cnt_q, cnt_d;
  logic [7:0]     sum_q, sum_d;
  afte_pkg::out_t out_q;
  logic           out_valid_q;
  logic [7:0]     len_clamp;
  logic [8:0]     total;
  logic [7:0]     cur_byte;
  logic [7:0]     hdr_byte;

  assign len_clamp = (in_req_i.frame_len > afte_pkg::MaxPayload) ?
                     afte_pkg::MaxPayload : in_req_i.frame_len;
  assign total     = {1'b0, cnt_q} + afte_pkg::LenExtra;

  // header field bytes, most significant first
  always_comb begin
    case (cmd_i.hdr_idx)
      4'd0:    hdr_byte = cfg_i.api_id;
      4'd1:    hdr_byte = cfg_i.frame_id;
      4'd2:    hdr_byte = cfg_i.dest_addr64[63:56];
      4'd3:    hdr_byte = cfg_i.dest_addr64[55:48];
      4'd4:    hdr_byte = cfg_i.dest_addr64[47:40];
      4'd5:    hdr_byte = cfg_i.dest_addr64[39:32];
      4'd6:    hdr_byte = cfg_i.dest_addr64[31:24];
      4'd7:    hdr_byte = cfg_i.dest_addr64[23:16];
      4'd8:    hdr_byte = cfg_i.dest_addr64[15:8];
      4'd9:    hdr_byte = cfg_i.dest_addr64[7:0];
      4'd10:   hdr_byte = cfg_i.dest_addr16[15:8];
      4'd11:   hdr_byte = cfg_i.dest_addr16[7:0];
      4'd12:   hdr_byte = cfg_i.radius;
      default: hdr_byte = cfg_i.tx_options;
    endcase
  end

  always_comb begin
    case (cmd_i.src)
      afte_pkg::SRC_START:  cur_byte = afte_pkg::StartMark;
      afte_pkg::SRC_LEN_HI: cur_byte = {7'd0, total[8]};
      afte_pkg::SRC_LEN_LO: cur_byte = total[7:0];
      afte_pkg::SRC_HDR:    cur_byte = hdr_byte;
      afte_pkg::SRC_DATA:   cur_byte = data_q;
      afte_pkg::SRC_CHECK:  cur_byte = ~sum_q;
      default:              cur_byte = 8'd0;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    if (cmd_i.take && cmd_i.first) begin
      cnt_d = len_clamp;
      sum_d = 8'd0;
    end else begin
      if (cmd_i.dec_cnt) begin
        cnt_d = cnt_q - 8'd1;
      end
      if (cmd_i.add_sum) begin
        sum_d = sum_q + cur_byte;
      end
    end
  end

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.needs_esc = afte_pkg::needs_escape(cur_byte);
  assign sts_o.cnt_zero  = (cnt_q == 8'd0);
  assign sts_o.cnt_one   = (cnt_q == 8'd1);

  assign out_rsp_o   = out_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      data_q <= in_req_i.data_byte;
    end
    if (cmd_i.emit) begin
      out_q.tx_byte   <= cmd_i.esc_mark ? afte_pkg::EscMark :
                         (cmd_i.flip ? (cur_byte ^ afte_pkg::EscFlip) : cur_byte);
      out_q.run_last  <= cmd_i.run_last;
      out_q.frame_end <= cmd_i.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= 8'd0;
      sum_q       <= 8'd0;
    end else begin
      cnt_q <= cnt_d;
      sum_q <= sum_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/afte_ctrl.sv =====
`default_nettype none
module afte_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire afte_pkg::sts_t sts_i,
  output afte_pkg::cmd_t      cmd_o
);

  afte_pkg::state_e state_q, state_d;
  logic             esc_q, esc_d;
  logic             in_frame_q, in_frame_d;
  logic [3:0]       hdr_idx_q, hdr_idx_d;
  logic             esc_need;
  logic             step;
  logic             fin;

  assign in_ready_o = (state_q == afte_pkg::ST_IDLE);

  // one output byte per step; a slot finishes on its last byte
  assign esc_need = sts_i.needs_esc && (state_q != afte_pkg::ST_START);
  assign step     = (state_q != afte_pkg::ST_IDLE) && sts_i.out_free;
  assign fin      = step && (esc_q || !esc_need);

  always_comb begin
    state_d    = state_q;
    esc_d      = esc_q;
    in_frame_d = in_frame_q;
    hdr_idx_d  = hdr_idx_q;
    if (step) begin
      esc_d = !fin;
    end
    case (state_q)
      afte_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = in_frame_q ? afte_pkg::ST_DATA : afte_pkg::ST_START;
        end
      end
      afte_pkg::ST_START: begin
        if (fin) state_d = afte_pkg::ST_LEN_HI;
      end
      afte_pkg::ST_LEN_HI: begin
        if (fin) state_d = afte_pkg::ST_LEN_LO;
      end
      afte_pkg::ST_LEN_LO: begin
        if (fin) begin
          state_d   = afte_pkg::ST_HDR;
          hdr_idx_d = 4'd0;
        end
      end
      afte_pkg::ST_HDR: begin
        if (fin) begin
          if (hdr_idx_q == afte_pkg::HdrLast) begin
            state_d = sts_i.cnt_zero ? afte_pkg::ST_CHECK : afte_pkg::ST_DATA;
          end else begin
            hdr_idx_d = hdr_idx_q + 4'd1;
          end
        end
      end
      afte_pkg::ST_DATA: begin
        if (fin) begin
          if (sts_i.cnt_one) begin
            state_d = afte_pkg::ST_CHECK;
          end else begin
            state_d    = afte_pkg::ST_IDLE;
            in_frame_d = 1'b1;
          end
        end
      end
      afte_pkg::ST_CHECK: begin
        if (fin) begin
          state_d    = afte_pkg::ST_IDLE;
          in_frame_d = 1'b0;
        end
      end
      default: state_d = afte_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.take      = in_ready_o && in_valid_i;
    cmd_o.first     = !in_frame_q;
    cmd_o.hdr_idx   = hdr_idx_q;
    cmd_o.emit      = step;
    cmd_o.esc_mark  = step && !esc_q && esc_need;
    cmd_o.flip      = esc_q;
    cmd_o.add_sum   = 1'b0;
    cmd_o.dec_cnt   = 1'b0;
    cmd_o.run_last  = 1'b0;
    cmd_o.frame_end = 1'b0;
    case (state_q)
      afte_pkg::ST_START:  cmd_o.src = afte_pkg::SRC_START;
      afte_pkg::ST_LEN_HI: cmd_o.src = afte_pkg::SRC_LEN_HI;
      afte_pkg::ST_LEN_LO: cmd_o.src = afte_pkg::SRC_LEN_LO;
      afte_pkg::ST_HDR: begin
        cmd_o.src     = afte_pkg::SRC_HDR;
        cmd_o.add_sum = fin;
      end
      afte_pkg::ST_DATA: begin
        cmd_o.src      = afte_pkg::SRC_DATA;
        cmd_o.add_sum  = fin;
        cmd_o.dec_cnt  = fin;
        cmd_o.run_last = fin && !sts_i.cnt_one;
      end
      afte_pkg::ST_CHECK: begin
        cmd_o.src       = afte_pkg::SRC_CHECK;
        cmd_o.run_last  = fin;
        cmd_o.frame_end = fin;
      end
      default: cmd_o.src = afte_pkg::SRC_START;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= afte_pkg::ST_IDLE;
      esc_q      <= 1'b0;
      in_frame_q <= 1'b0;
      hdr_idx_q  <= 4'd0;
    end else begin
      state_q    <= state_d;
      esc_q      <= esc_d;
      in_frame_q <= in_frame_d;
      hdr_idx_q  <= hdr_idx_d;
    end
  end

  // a pending escape half never survives into idle
  a_esc_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> (state_q != afte_pkg::ST_IDLE))
    else $error("escape pending while idle");

  // the escape mark is always followed by its second half
  a_esc_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.esc_mark |=> (esc_q && (state_q == $past(state_q))))
    else $error("escape half lost");

  // the frame end is always the last byte of its request
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.frame_end |-> (cmd_o.run_last && (state_d == afte_pkg::ST_IDLE) && !in_frame_d))
    else $error("frame end without request end");

  // header index stays within the header
  a_hdr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == afte_pkg::ST_HDR) |-> (hdr_idx_q <= afte_pkg::HdrLast))
    else $error("header index out of range");

endmodule
`default_nettype wire

// ===== design/api_frame_tx_escaper.sv =====
// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+---------------------------------------
// in        | input     | in_valid_i / in_ready_o  | in_req_i  (data_byte, frame_len)
// out       | output    | out_valid_o / out_ready_i| out_rsp_o (tx_byte, run_last, frame_end)
// cfg       | input     | psel/penable/pwrite      | paddr, pwdata, prdata (64-bit apb)
//
// a request is taken while idle, then one line byte per cycle through a single output register
// first request of a frame: start, length, 14 header bytes, then data, checksum or both,
//   each escaped byte costing one extra line byte; later requests: data, plus checksum on the last
// the byte sequencer in the controller walks these slots; one request is in work at a time
// out_ready_i low holds the output register and freezes the sequencer until it drains
// reset clears frame state and loads register defaults (dest_addr16 0xfffe, api id 0x10,
//   frame id 1); no clearing pass is needed
`default_nettype none
module api_frame_tx_escaper (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  // payload bytes in
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire afte_pkg::in_t  in_req_i,
  // escaped line bytes out
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output afte_pkg::out_t      out_rsp_o,
  // register port, register i at byte address 8*i
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [5:0]     paddr,
  input  wire logic [63:0]    pwdata,
  output logic      [63:0]    prdata,
  output logic                pready
);

  afte_pkg::cfg_t cfg;
  afte_pkg::cmd_t cmd;
  afte_pkg::sts_t sts;

  // header fields, read by the datapath while a frame header goes out
  afte_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: walks start, length, header, data and checksum slots and splits escapes
  afte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // byte selection, length and checksum arithmetic, output register
  afte_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .out_valid_o (out_valid_o),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire

// ===== tb/api_frame_tx_escaper_tb.sv =====
`default_nettype none
module api_frame_tx_escaper_tb;

  // run limits, in clock cycles but for PrintCap, which caps the printed mismatches
  localparam int CycleLimit   = 2_000_000;
  localparam int SettleCycles = 40;
  localparam int HoldCycles   = 300;
  localparam int PrintCap     = 100;

  // register index past the end of the map, writes to it must be dropped
  localparam logic [2:0] RegBeyond = 3'd6;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request side
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  afte_pkg::in_t  in_req_i   = '0;

  // line byte side
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  afte_pkg::out_t out_rsp_o;

  // register port
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [5:0]  paddr   = '0;
  logic [63:0] pwdata  = '0;
  logic [63:0] prdata;
  logic        pready;

  api_frame_tx_escaper dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // requests waiting to be offered, filled by the stimulus process
  afte_pkg::in_t  payload_q[$];
  int             items_queued = 0;

  // line bytes the block still owes, oldest first
  afte_pkg::out_t line_bytes_q[$];

  // register copy as the block should hold it (reset values)
  afte_pkg::cfg_t cfg_now = '{dest_addr64: 64'd0, dest_addr16: 16'hFFFE, radius: 8'd0,
                              tx_options: 8'd0, api_id: 8'h10, frame_id: 8'h01};

  // frame state of the model
  logic       framing_q = 1'b0;
  logic [7:0] left_q    = '0;
  logic [7:0] csum_q    = '0;

  // last byte of the current burst is held back until its run_last is known
  afte_pkg::out_t staged;
  logic           have_staged = 1'b0;

  // handshake bookkeeping between the sampling and the driving edges
  int taken_cnt = 0;
  int seen_cnt  = 0;
  int gap_left  = 0;
  int stall_left = 0;

  int   cycles = 0;
  int   errors = 0;
  logic calm      = 1'b0;  // no idling on either side while set
  logic hold_go   = 1'b0;
  logic long_hold = 1'b0;

  // ---------------------------------------------------------------------------
  // model of the escaper
  // ---------------------------------------------------------------------------

  function automatic logic is_ctrl_char(input logic [7:0] b);
    return (b == afte_pkg::StartMark) || (b == afte_pkg::EscMark) ||
           (b == afte_pkg::Xon) || (b == afte_pkg::Xoff);
  endfunction

  // k-th checksummed header byte: api id, frame id, dest64 msb first, dest16, radius, options
  function automatic logic [7:0] header_byte(input int k);
    case (k)
      0:       return cfg_now.api_id;
      1:       return cfg_now.frame_id;
      10:      return cfg_now.dest_addr16[15:8];
      11:      return cfg_now.dest_addr16[7:0];
      12:      return cfg_now.radius;
      13:      return cfg_now.tx_options;
      default: return 8'(cfg_now.dest_addr64 >> (8 * (9 - k)));
    endcase
  endfunction

  task automatic stage_byte(input logic [7:0] b, input logic ends_frame);
    if (have_staged) line_bytes_q.push_back(staged);
    staged.tx_byte   = b;
    staged.run_last  = 1'b0;
    staged.frame_end = ends_frame;
    have_staged      = 1'b1;
  endtask

  // control characters go out as escape mark plus the flipped byte
  task automatic put_line(input logic [7:0] b, input logic ends_frame);
    if (is_ctrl_char(b)) begin
      stage_byte(afte_pkg::EscMark, 1'b0);
      stage_byte(b ^ afte_pkg::EscFlip, ends_frame);
    end else begin
      stage_byte(b, ends_frame);
    end
  endtask

  task automatic put_summed(input logic [7:0] b);
    put_line(b, 1'b0);
    csum_q = csum_q + b;
  endtask

  task automatic put_checksum();
    put_line(8'hFF - csum_q, 1'b1);
    framing_q = 1'b0;
    left_q    = '0;
    csum_q    = '0;
  endtask

  // expected line bytes for one accepted request
  task automatic predict_line(input afte_pkg::in_t req);
    logic [7:0] n;
    logic [8:0] total;
    int         k;
    if (!framing_q) begin
      n     = (req.frame_len > afte_pkg::MaxPayload) ? afte_pkg::MaxPayload : req.frame_len;
      total = {1'b0, n} + afte_pkg::LenExtra;
      csum_q = '0;
      stage_byte(afte_pkg::StartMark, 1'b0);
      put_line({7'd0, total[8]}, 1'b0);
      put_line(total[7:0], 1'b0);
      for (k = 0; k <= int'(afte_pkg::HdrLast); k++) put_summed(header_byte(k));
      if (n == 8'd0) begin
        // empty frame: data byte is dropped
        put_checksum();
      end else begin
        put_summed(req.data_byte);
        left_q = n - 8'd1;
        if (left_q == 8'd0) put_checksum();
        else framing_q = 1'b1;
      end
    end else begin
      // the length field is ignored inside a frame
      put_summed(req.data_byte);
      left_q = left_q - 8'd1;
      if (left_q == 8'd0) put_checksum();
    end
    staged.run_last = 1'b1;
    line_bytes_q.push_back(staged);
    have_staged = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // idle length: mostly none, some short, a few long
  function automatic int idle_len(input int longest);
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, longest);
  endfunction

  // payload bytes lean on the control characters
  function automatic logic [7:0] pick_data();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0:       return afte_pkg::StartMark;
      1:       return afte_pkg::EscMark;
      2:       return afte_pkg::Xon;
      default: return afte_pkg::Xoff;
    endcase
  endfunction

  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 8'd0;
    if (r < 80) return 8'($urandom_range(1, 8));
    if (r < 95) return 8'($urandom_range(9, 30));
    return 8'($urandom_range(31, 80));
  endfunction

  // one whole frame: first request carries the length, the rest random length fields
  task automatic add_frame(input logic [7:0] len_field, input logic [7:0] first_data);
    afte_pkg::in_t r;
    int            n;
    int            i;
    n = (len_field > afte_pkg::MaxPayload) ? int'(afte_pkg::MaxPayload) : int'(len_field);
    r.data_byte = first_data;
    r.frame_len = len_field;
    payload_q.push_back(r);
    items_queued++;
    for (i = 1; i < n; i++) begin
      r.data_byte = pick_data();
      r.frame_len = 8'($urandom_range(0, 255));
      payload_q.push_back(r);
      items_queued++;
    end
  endtask

  task automatic add_random(input int count);
    int stop_at;
    stop_at = items_queued + count;
    while (items_queued < stop_at) add_frame(pick_len(), pick_data());
  endtask

  // setup then access phase, write lands when psel/penable/pwrite/pready are high
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      afte_pkg::RegDest64:  cfg_now.dest_addr64 = v;
      afte_pkg::RegDest16:  cfg_now.dest_addr16 = v[15:0];
      afte_pkg::RegRadius:  cfg_now.radius      = v[7:0];
      afte_pkg::RegOptions: cfg_now.tx_options  = v[7:0];
      afte_pkg::RegApiId:   cfg_now.api_id      = v[7:0];
      afte_pkg::RegFrameId: cfg_now.frame_id    = v[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // narrow registers get junk in the upper bits, which must be dropped
  task automatic load_config(input afte_pkg::cfg_t c);
    logic [63:0] junk;
    junk = {$urandom(), $urandom()};
    write_reg(afte_pkg::RegDest64, c.dest_addr64);
    write_reg(afte_pkg::RegDest16, {junk[63:16], c.dest_addr16});
    write_reg(afte_pkg::RegRadius, {junk[63:8], c.radius});
    write_reg(afte_pkg::RegOptions, {junk[63:8], c.tx_options});
    write_reg(afte_pkg::RegApiId, {junk[63:8], c.api_id});
    write_reg(afte_pkg::RegFrameId, {junk[63:8], c.frame_id});
    write_reg(RegBeyond, junk);
  endtask

  // wait for every request to go in and every line byte to come out
  task automatic settle();
    while (payload_q.size() != 0 || in_valid_i || line_bytes_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (errors < PrintCap)
      $display("cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // request driver: changes on the falling edge, holds until the request is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : feed
    afte_pkg::in_t nxt_req;
    logic          nxt_valid;
    nxt_req   = in_req_i;
    nxt_valid = in_valid_i;
    if (taken_cnt != seen_cnt) begin
      seen_cnt  = taken_cnt;
      nxt_valid = 1'b0;
    end
    if (rst_ni && !nxt_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (payload_q.size() > 0) begin
        nxt_req   = payload_q.pop_front();
        nxt_valid = 1'b1;
        gap_left  = idle_len(30);
      end
    end
    in_valid_i <= nxt_valid;
    in_req_i   <= nxt_req;
  end

  // line side back-pressure, plus the long hold-off when it is running
  always @(negedge clk_i) begin : drain
    if (long_hold) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      stall_left = idle_len(20);
    end
  end

  // receiver stops draining long enough for the block to back up into the request side
  initial begin : rx_hold
    wait (hold_go);
    long_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    long_hold = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // monitor: checks line bytes, then feeds accepted requests to the model
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    afte_pkg::out_t want;
    if (rst_ni) begin
      cycles++;
      if (out_valid_o && out_ready_i) begin
        if (line_bytes_q.size() == 0) begin
          report_mismatch("line byte with none expected", out_rsp_o.tx_byte, 8'h00);
        end else begin
          want = line_bytes_q.pop_front();
          if (out_rsp_o.tx_byte != want.tx_byte)
            report_mismatch("tx_byte", out_rsp_o.tx_byte, want.tx_byte);
          if (out_rsp_o.run_last != want.run_last)
            report_mismatch("run_last", {7'd0, out_rsp_o.run_last}, {7'd0, want.run_last});
          if (out_rsp_o.frame_end != want.frame_end)
            report_mismatch("frame_end", {7'd0, out_rsp_o.frame_end},
                            {7'd0, want.frame_end});
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_line(in_req_i);
        taken_cnt++;
      end
      if (cycles > CycleLimit) begin
        $display("api_frame_tx_escaper_tb: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: directed frames on reset registers, then random phases
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    afte_pkg::cfg_t c;
    logic [7:0]     hs;
    int             k;
    int             ph;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sum of header bytes, to aim the checksum at control characters
    hs = '0;
    for (k = 0; k <= int'(afte_pkg::HdrLast); k++) hs = hs + header_byte(k);

    // empty frames, data byte dropped
    add_frame(8'd0, afte_pkg::StartMark);
    add_frame(8'd0, 8'hFF);
    // single byte frames at the data extremes
    add_frame(8'd1, 8'h00);
    add_frame(8'd1, 8'hFF);
    // length low byte lands on xon and xoff
    add_frame(8'd3, afte_pkg::StartMark);
    add_frame(8'd5, afte_pkg::EscMark);
    // escaped checksum, frame_end on the flipped half
    add_frame(8'd1, 8'hFF - afte_pkg::StartMark - hs);
    add_frame(8'd1, 8'hFF - afte_pkg::EscMark - hs);
    add_frame(8'd1, 8'hFF - afte_pkg::Xon - hs);
    add_frame(8'd1, 8'hFF - afte_pkg::Xoff - hs);
    settle();

    for (ph = 1; ph <= 6; ph++) begin
      case (ph)
        1: c = '0;
        2: c = '1;
        3: c = '{dest_addr64: 64'h7E7D_1113_7E7D_1113, dest_addr16: 16'h7D7E,
                 radius: afte_pkg::Xon, tx_options: afte_pkg::Xoff,
                 api_id: afte_pkg::StartMark, frame_id: afte_pkg::EscMark};
        default: begin
          c.dest_addr64 = {$urandom(), $urandom()};
          c.dest_addr16 = 16'($urandom());
          c.radius      = 8'($urandom());
          c.tx_options  = 8'($urandom());
          c.api_id      = 8'($urandom());
          c.frame_id    = 8'($urandom());
        end
      endcase
      load_config(c);
      @(posedge clk_i);
      calm = (ph == 3);
      if (ph == 2) hold_go = 1'b1;
      // over-long length, clamped, length high byte goes to one
      if (ph == 1) add_frame(8'd255, pick_data());
      add_random(25);
      settle();
    end

    if (errors == 0) begin
      $display("api_frame_tx_escaper_tb: clean");
    end else begin
      $display("api_frame_tx_escaper_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== api_frame_tx_escaper.f =====
design/afte_pkg.sv
design/afte_cfg.sv
design/afte_dp.sv
design/afte_ctrl.sv
design/api_frame_tx_escaper.sv
tb/api_frame_tx_escaper_tb.sv
